// File: hw/rtl/xsr_pkg.sv
// xsr_pkg: shared types and constants for the four-lane xoshiro256+ generator
// no dependencies
`timescale 1ns / 1ps
package xsr_pkg;

  typedef enum logic [2:0] {
    OP_SEED  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_READ  = 3'd2,
    OP_RAW   = 3'd3,
    OP_BOUND = 3'd4,
    OP_FRAC  = 3'd5
  } opcode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] operand_value;
    logic [3:0]  word_index;
    logic [63:0] time_value;
  } req_t;

  localparam logic [63:0] MIX_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] MIX_ADD   = 64'd1442695040888963407;
  localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

  function automatic logic [63:0] seed_word(input logic [1:0] lane, input logic [1:0] word);
    logic [63:0] r;
    unique case ({lane, word})
      4'd0:  r = 64'hd5a986ae75c9a33b;
      4'd1:  r = 64'h1016d8e3483a8f0f;
      4'd2:  r = 64'h81f9e6260eb8e5df;
      4'd3:  r = 64'hfa9b718d8d0769bf;
      4'd4:  r = 64'h9c57a73dcd5e41b7;
      4'd5:  r = 64'hcb0c33c0e78feede;
      4'd6:  r = 64'h5943e008d9222efa;
      4'd7:  r = 64'h4d46d3d50833e8c9;
      4'd8:  r = 64'h3fe497b4dd1be68d;
      4'd9:  r = 64'h7b5dda788f9f577d;
      4'd10: r = 64'h8f514f6e6fb18ba4;
      4'd11: r = 64'h696678daaa7b4cc6;
      4'd12: r = 64'h3f57adc392affdef;
      4'd13: r = 64'hf1e01f806161118a;
      4'd14: r = 64'h6dacfe2135f9599e;
      default: r = 64'h3cb5c708d53cc982;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/xsr_front.sv
// xsr_front: two-entry request queue between the input port and the engine
// depends on xsr_pkg
`timescale 1ns / 1ps
module xsr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xsr_pkg::req_t push_req,
  output logic          full,
  output logic          req_valid,
  output xsr_pkg::req_t req,
  input  logic          req_take
);
  import xsr_pkg::*;

  req_t       q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = cnt_r == 2'd2;
  assign req_valid = cnt_r != 2'd0;
  assign req       = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_comb begin
    rd_nxt  = rd_r ^ do_pop;
    wr_nxt  = wr_r ^ do_push;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= push_req;
  end

endmodule

// File: hw/rtl/xsr_back.sv
// xsr_back: state words, draw buffer, seeding, bound reduction and result register
// depends on xsr_pkg
`timescale 1ns / 1ps
module xsr_back #(
  parameter int LANES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  xsr_pkg::req_t req,
  output logic          req_take,
  output logic          res_valid,
  output logic [63:0]   res_value,
  input  logic          res_pop
);
  import xsr_pkg::*;

  localparam int NW = 4 * LANES;
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CW = $clog2(LANES + 1);
  localparam int SW = $clog2(NW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEED_MUL, ST_SEED_ADD, ST_DRAW, ST_MUL, ST_DIV, ST_DONE
  } st_t;

  st_t st_r, st_nxt;
  logic [63:0] w_r [NW];
  logic [63:0] buf_r [LANES];
  logic [CW-1:0] cnt_r;
  req_t        cur_r;
  logic [63:0] v_r, prod_r, res_r;
  logic [31:0] crs_r;
  logic [LW-1:0] slane_r;
  logic [1:0]  sword_r;
  logic [63:0] dq_r, drem_r;
  logic [6:0]  dstep_r;
  logic [63:0] draw_w;
  logic [64:0] rem_sh, rem_sub;
  logic [CW-1:0] cnt_use;
  logic [63:0] mul_ll, mul_lh, mul_hl, mul_b, v_nxt;

  assign req_take  = st_r == ST_IDLE && req_valid && !res_valid;
  assign res_valid = st_r == ST_DONE;
  assign res_value = res_r;

  // word of the draw: from the state words when the buffer is refilled in this cycle, else from the buffer
  assign cnt_use = (cnt_r == '0 || cnt_r > CW'(LANES)) ? CW'(LANES) : cnt_r;
  always_comb begin
    logic [LW-1:0] e;
    e = LW'(cnt_use - 1'b1);
    if (cnt_r == '0 || cnt_r > CW'(LANES))
      draw_w = w_r[SW'({e, 2'b00})] + w_r[SW'({e, 2'b11})];
    else
      draw_w = buf_r[e];
  end

  // low 64 bits of v * MIX_MUL + MIX_ADD from 32-bit partial products
  assign mul_ll = v_r[31:0] * MIX_MUL[31:0];
  assign mul_lh = v_r[31:0] * MIX_MUL[63:32];
  assign mul_hl = v_r[63:32] * MIX_MUL[31:0];
  assign v_nxt  = prod_r + {crs_r, 32'd0} + MIX_ADD;

  assign mul_b = dq_r[31:0] * cur_r.operand_value[31:0];

  assign rem_sh  = {drem_r, dq_r[63]};
  assign rem_sub = rem_sh - {1'b0, cur_r.operand_value};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (req_take) begin
        unique case (req.opcode)
          OP_SEED: st_nxt = ST_SEED_MUL;
          OP_RAW, OP_BOUND, OP_FRAC: st_nxt = ST_DRAW;
          default: st_nxt = ST_DONE;
        endcase
      end
      ST_SEED_MUL: st_nxt = ST_SEED_ADD;
      ST_SEED_ADD: st_nxt = (slane_r == LW'(LANES - 1) && sword_r == 2'd3) ?
                            ST_DONE : ST_SEED_MUL;
      ST_DRAW: begin
        if (cur_r.opcode == OP_BOUND)
          st_nxt = (cur_r.operand_value[63:32] != '0) ? ST_DIV : ST_MUL;
        else
          st_nxt = ST_DONE;
      end
      ST_MUL: st_nxt = ST_DONE;
      ST_DIV: if (dstep_r == 7'd63) st_nxt = ST_DONE;
      ST_DONE: if (res_pop) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++)
        w_r[i] <= seed_word(2'(i / 4), 2'(i % 4));
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: if (req_take) begin
          cur_r   <= req;
          res_r   <= '0;
          slane_r <= '0;
          sword_r <= '0;
          v_r     <= (req.operand_value != '0) ? req.operand_value : req.time_value;
          if (req.opcode == OP_LOAD && 32'(req.word_index) < NW) begin
            w_r[SW'(req.word_index)] <= req.operand_value;
            cnt_r <= '0;
          end
          if (req.opcode == OP_READ && 32'(req.word_index) < NW)
            res_r <= w_r[SW'(req.word_index)];
        end
        ST_SEED_MUL: begin
          prod_r <= mul_ll;
          crs_r  <= mul_lh[31:0] + mul_hl[31:0];
        end
        ST_SEED_ADD: begin
          // lane-major within each word: index = lane*4 + word
          v_r <= v_nxt;
          w_r[SW'({slane_r, sword_r})] <= v_nxt;
          if (slane_r == LW'(LANES - 1)) begin
            slane_r <= '0;
            sword_r <= sword_r + 1'b1;
          end else begin
            slane_r <= slane_r + 1'b1;
          end
        end
        ST_DRAW: begin
          if (cnt_r == '0 || cnt_r > CW'(LANES)) begin
            for (int l = 0; l < LANES; l++) begin
              logic [63:0] a0, a1, a2, a3;
              a0 = w_r[4*l]; a1 = w_r[4*l+1]; a2 = w_r[4*l+2]; a3 = w_r[4*l+3];
              buf_r[l] <= a0 + a3;
              a2 = a2 ^ a0;
              a3 = a3 ^ a1;
              a1 = a1 ^ a2;
              a0 = a0 ^ a3;
              a2 = a2 ^ (w_r[4*l+1] << 17);
              w_r[4*l]   <= a0;
              w_r[4*l+1] <= a1;
              w_r[4*l+2] <= a2;
              w_r[4*l+3] <= {a3[18:0], a3[63:19]};
            end
          end
          cnt_r   <= cnt_use - 1'b1;
          dq_r    <= draw_w;
          drem_r  <= '0;
          dstep_r <= '0;
          if (cur_r.opcode == OP_FRAC) res_r <= draw_w & FRAC_MASK;
          else                         res_r <= draw_w;
        end
        ST_MUL: res_r <= {32'd0, mul_b[63:32]};
        ST_DIV: begin
          // restoring division, one quotient bit a cycle, keep the remainder
          if (!rem_sub[64]) drem_r <= rem_sub[63:0];
          else              drem_r <= rem_sh[63:0];
          dq_r    <= {dq_r[62:0], 1'b0};
          dstep_r <= dstep_r + 1'b1;
          if (dstep_r == 7'd63) res_r <= !rem_sub[64] ? rem_sub[63:0] : rem_sh[63:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/xoshiro256_plus_four_lane_prng_top.sv
// channel   direction  handshake         payload
// in_       input      in_push/in_full   opcode, operand_value, word_index, time_value
// out_      output     out_empty/out_pop result_value
//
// one request at a time: load/read, raw draw and fraction, bounded draw with a
// bound below 2^32 or with a larger bound (bit-serial divider), and seed
// (32-bit partial products, then the add, per state word).
// reset is synchronous; a two-entry request queue keeps taking transfers,
// until both entries are full, while the engine works or a result waits on out_pop.
// Depends on xsr_pkg, xsr_front, xsr_back.
`timescale 1ns / 1ps
module xoshiro256_plus_four_lane_prng_top #(
  parameter int LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_operand_value,
  input  logic [3:0]  in_word_index,
  input  logic [63:0] in_time_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_result_value
);
  import xsr_pkg::*;

  req_t        push_req, req;
  logic        req_valid, req_take, res_valid;

  assign push_req = '{opcode: in_opcode, operand_value: in_operand_value,
                      word_index: in_word_index, time_value: in_time_value};

  xsr_front u_front (
    .clk, .rst_n, .push(in_push), .push_req, .full(in_full),
    .req_valid, .req, .req_take
  );

  xsr_back #(.LANES(LANES)) u_back (
    .clk, .rst_n, .req_valid, .req, .req_take,
    .res_valid, .res_value(out_result_value), .res_pop(out_pop)
  );

  assign out_empty = !res_valid;

  a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> req_valid && out_empty) else $error("request taken while busy");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_result_value))
    else $error("result changed before transfer");
  a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !req_take) else $error("engine started with result pending");

endmodule
